[rtl/sbcr_pkg.sv]
// sbcr_pkg: shared types and constants of the bus client responder
// no dependencies; imported by every module of the block
`default_nettype none

package sbcr_pkg;

    localparam int SBCR_FRAME_DEPTH = 35;
    localparam int REPLY_MAX        = 11;

    localparam logic [7:0] SOF_BYTE  = 8'h7E;
    localparam logic [7:0] NODE_TAG  = 8'hBF;
    localparam logic [7:0] ID_LIMIT  = 8'h2F;
    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CRC_SEED  = 8'h02;
    localparam logic [7:0] CRC_XOR   = 8'h02;

    localparam logic [7:0] ADDR_OFFER = 8'hFE;
    localparam logic [7:0] ADDR_BCAST = 8'hFF;

    localparam logic [7:0] TYPE_ID_OFFER  = 8'h00;
    localparam logic [7:0] TYPE_ID_ASSIGN = 8'h02;
    localparam logic [7:0] TYPE_CTS       = 8'h06;
    localparam logic [7:0] TYPE_STATUS    = 8'h13;
    localparam logic [7:0] TYPE_FILTER    = 8'h23;
    localparam logic [7:0] TYPE_FAULT     = 8'h28;
    localparam logic [7:0] TYPE_CONFIG    = 8'h2E;

    localparam logic [7:0] CMD_NONE   = 8'h00;
    localparam logic [7:0] CMD_CLOCK  = 8'h21;
    localparam logic [7:0] CMD_FILTER = 8'h23;
    localparam logic [7:0] CMD_TEMP   = 8'hFF;

    localparam logic [7:0] MSG_ID_ACK    = 8'h03;
    localparam logic [7:0] MSG_NOTHING   = 8'h07;
    localparam logic [7:0] MSG_TOGGLE    = 8'h11;
    localparam logic [7:0] MSG_TEMP      = 8'h20;
    localparam logic [7:0] MSG_INFO_REQ  = 8'h22;

    typedef enum logic [1:0] {
        OP_RX_BYTE  = 2'd0,
        OP_SET_CMD  = 2'd1,
        OP_SET_TEMP = 2'd2,
        OP_UNUSED   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_LOAD,
        S_SHIFT,
        S_SEND
    } state_t;

    typedef struct packed {
        logic init;
        logic absorb;
    } crc_ctl_t;

endpackage

`default_nettype wire

[rtl/sbcr_rx_if.sv]
// sbcr_rx_if: request channel into the responder (opcode and value)
// no dependencies
`default_nettype none

interface sbcr_rx_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

[rtl/sbcr_tx_if.sv]
// sbcr_tx_if: reply byte channel out of the responder
// no dependencies
`default_nettype none

interface sbcr_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, output tx_byte, output last_byte, input ready);
    modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/spa_bus_client_responder.sv]
// spa_bus_client_responder: frame assembly, dispatch and reply generation
// depends on sbcr_pkg, sbcr_rx_if, sbcr_tx_if, sbcr_crc_unit
//
//   channel | dir | fields              | request
//   rx      | in  | opcode, value       | one received byte or a command write
//   tx      | out | tx_byte, last_byte  | one reply byte, last on closing 0x7E
//
// a request is taken in S_IDLE; a closing byte of a frame of five or more
// bytes then passes S_READ (check-byte memory read) and S_CHECK (dispatch);
// start, crc and closing bytes pass S_LOAD and S_SEND, which waits on the receiver;
// length and payload bytes pass S_LOAD, S_SHIFT (8 crc shifts), S_SEND; rx is
// not ready from such a closing byte to the end of dispatch or of the reply
// reset clears all stored status; the frame buffer, reply payload and output byte are not cleared
`default_nettype none

module spa_bus_client_responder
    import sbcr_pkg::*;
#(
    parameter int FRAME_DEPTH = SBCR_FRAME_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    sbcr_rx_if.sink   rx,
    sbcr_tx_if.source tx
);

    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(FRAME_DEPTH);

    state_t state_reg, state_next;

    // frame storage: memory for indexed reads, shadows for fixed positions
    logic [7:0]    mem [FRAME_DEPTH];
    logic [7:0]    rd_reg;
    logic [7:0]    shadow_reg [1:12];
    logic [CW-1:0] count_reg, count_next;

    // stored status
    logic [5:0] node_reg, node_next;
    logic [7:0] pending_reg, pending_next;
    logic [7:0] target_reg;
    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [7:0] check_last_reg, check_last_next;
    logic       have_cfg_reg, have_cfg_next;
    logic       have_fault_reg, have_fault_next;
    logic       have_filt_reg, have_filt_next;
    logic [7:0] filt_reg [8];
    logic [7:0] filt_next [8];

    // reply
    logic [7:0] pl_reg [REPLY_MAX];
    logic [7:0] pl_next [REPLY_MAX];
    logic [3:0] n_reg, n_next;
    logic       reply;
    logic [3:0] e_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [7:0] cur_byte;
    logic       cur_absorb;

    crc_ctl_t   crc_ctl;
    logic [7:0] crc_val;
    logic       crc_busy;

    // request decode
    op_t  op;
    logic rx_fire;
    logic wr_en;
    logic drop_frame;
    logic close;
    logic [CW-1:0] count_inc;

    assign op        = op_t'(rx.opcode);
    assign rx.ready  = (state_reg == S_IDLE);
    assign rx_fire   = rx.valid && rx.ready;
    assign count_inc = count_reg + CW'(1);

    always_comb
    begin
        wr_en      = 1'b0;
        drop_frame = 1'b0;
        if (rx_fire && op == OP_RX_BYTE)
        begin
            // hunt for start byte, collapse doubled start byte
            if (!((count_reg == '0 && rx.value != SOF_BYTE) ||
                  (count_reg == CW'(1) && rx.value == SOF_BYTE)))
            begin
                if (count_reg < CW'(FRAME_DEPTH))
                    wr_en = 1'b1;
                else
                    drop_frame = 1'b1;
            end
        end
    end

    assign close = wr_en && (rx.value == SOF_BYTE) && (count_reg >= CW'(2));

    // frame byte at a fixed index, zero beyond the frame
    function automatic logic [7:0] fa(input logic [CW-1:0] cnt,
                                      input logic [7:0] b, input int idx);
        return (CW'(idx) < cnt) ? b : 8'h00;
    endfunction

    logic [7:0] addr_b, type_b, b1, check_b, id_clamp;
    logic [7:0] fb [5:12];
    logic       registered, addr_me;

    assign b1       = fa(count_reg, shadow_reg[1], 1);
    assign addr_b   = fa(count_reg, shadow_reg[2], 2);
    assign type_b   = fa(count_reg, shadow_reg[4], 4);
    assign check_b  = (b1 < 8'(count_reg)) ? rd_reg : 8'h00;
    assign id_clamp = (fb[5] > ID_LIMIT) ? ID_LIMIT : fb[5];
    assign registered = (node_reg != '0);
    assign addr_me  = (addr_b == {2'b00, node_reg});

    for (genvar g = 5; g <= 12; g++)
    begin : g_fb
        assign fb[g] = fa(count_reg, shadow_reg[g], g);
    end

    // dispatch of a closed frame
    always_comb
    begin
        reply           = 1'b0;
        n_next          = n_reg;
        node_next       = node_reg;
        pending_next    = pending_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        check_last_next = check_last_reg;
        have_cfg_next   = have_cfg_reg;
        have_fault_next = have_fault_reg;
        have_filt_next  = have_filt_reg;
        for (int i = 0; i < 8; i++)
            filt_next[i] = filt_reg[i];
        for (int i = 0; i < REPLY_MAX; i++)
            pl_next[i] = 8'h00;
        pl_next[0] = {2'b00, node_reg};
        pl_next[1] = NODE_TAG;

        if (!registered)
        begin
            if (addr_b == ADDR_OFFER && type_b == TYPE_ID_ASSIGN)
            begin
                node_next  = id_clamp[5:0];
                reply      = 1'b1;
                n_next     = 4'd3;
                pl_next[0] = id_clamp;
                pl_next[2] = MSG_ID_ACK;
            end
            else if (addr_b == ADDR_OFFER && type_b == TYPE_ID_OFFER)
            begin
                reply      = 1'b1;
                n_next     = 4'd6;
                pl_next[0] = ADDR_OFFER;
                pl_next[2] = 8'h01;
                pl_next[3] = 8'h02;
                pl_next[4] = 8'hF1;
                pl_next[5] = 8'h73;
            end
        end
        else if (addr_me && type_b == TYPE_CTS)
        begin
            reply        = 1'b1;
            pending_next = CMD_NONE;
            priority if (pending_reg == CMD_CLOCK)
            begin
                n_next     = 4'd5;
                pl_next[2] = CMD_CLOCK;
                pl_next[3] = {3'b000, hour_reg};
                pl_next[4] = {2'b00, minute_reg};
            end
            else if (pending_reg == CMD_TEMP)
            begin
                n_next     = 4'd4;
                pl_next[2] = MSG_TEMP;
                pl_next[3] = target_reg;
            end
            else if (pending_reg == CMD_FILTER)
            begin
                n_next     = 4'd11;
                pl_next[2] = CMD_FILTER;
                for (int i = 0; i < 8; i++)
                    pl_next[3 + i] = filt_reg[i];
            end
            else if (pending_reg == CMD_NONE)
            begin
                priority if (!have_cfg_reg)
                begin
                    n_next     = 4'd6;
                    pl_next[2] = MSG_INFO_REQ;
                    pl_next[5] = 8'h01;
                end
                else if (!have_fault_reg)
                begin
                    n_next     = 4'd6;
                    pl_next[2] = MSG_INFO_REQ;
                    pl_next[3] = 8'h20;
                    pl_next[4] = 8'hFF;
                end
                else if (!have_filt_reg)
                begin
                    n_next     = 4'd6;
                    pl_next[2] = MSG_INFO_REQ;
                    pl_next[3] = 8'h01;
                end
                else
                begin
                    n_next     = 4'd3;
                    pl_next[2] = MSG_NOTHING;
                end
            end
            else
            begin
                n_next     = 4'd5;
                pl_next[2] = MSG_TOGGLE;
                pl_next[3] = pending_reg;
            end
        end
        else if (check_b != check_last_reg)
        begin
            priority if (addr_me && type_b == TYPE_CONFIG)
                have_cfg_next = 1'b1;
            else if (addr_me && type_b == TYPE_FAULT)
                have_fault_next = 1'b1;
            else if (addr_b == ADDR_BCAST && type_b == TYPE_STATUS)
            begin
                hour_next       = fb[8][4:0];
                minute_next     = fb[9][5:0];
                check_last_next = check_b;
            end
            else if (addr_me && type_b == TYPE_FILTER)
            begin
                filt_next[0]   = fb[5] & 8'h1F;
                filt_next[1]   = fb[6] & 8'h3F;
                filt_next[2]   = fb[7] & 8'h1F;
                filt_next[3]   = fb[8] & 8'h3F;
                filt_next[4]   = fb[9] & 8'h9F;
                filt_next[5]   = fb[10] & 8'h3F;
                filt_next[6]   = fb[11] & 8'h1F;
                filt_next[7]   = fb[12] & 8'h3F;
                have_filt_next = 1'b1;
            end
        end
    end

    // reply byte at emit index: sof, length, payload, crc, sof
    always_comb
    begin
        cur_byte   = SOF_BYTE;
        cur_absorb = 1'b0;
        if (e_reg == 4'd0)
            cur_byte = SOF_BYTE;
        else if (e_reg == 4'd1)
        begin
            cur_byte   = 8'(n_reg) + 8'd2;
            cur_absorb = 1'b1;
        end
        else if (e_reg <= n_reg + 4'd1)
        begin
            cur_byte   = pl_reg[e_reg - 4'd2];
            cur_absorb = 1'b1;
        end
        else if (e_reg == n_reg + 4'd2)
            cur_byte = crc_val ^ CRC_XOR;
    end

    // frame count
    always_comb
    begin
        count_next = count_reg;
        if (drop_frame)
            count_next = '0;
        else if (close)
            count_next = (count_inc > CW'(4)) ? count_inc : '0;
        else if (wr_en)
            count_next = count_inc;
        else if (state_reg == S_CHECK)
            count_next = '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (close && count_inc > CW'(4))
                    state_next = S_READ;
            S_READ:
                state_next = S_CHECK;
            S_CHECK:
                state_next = reply ? S_LOAD : S_IDLE;
            S_LOAD:
                state_next = cur_absorb ? S_SHIFT : S_SEND;
            S_SHIFT:
                if (!crc_busy)
                    state_next = S_SEND;
            S_SEND:
                if (tx.ready)
                    state_next = out_last_reg ? S_IDLE : S_LOAD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        crc_ctl.init   = 1'b0;
        crc_ctl.absorb = 1'b0;
        unique case (state_reg)
            S_CHECK: crc_ctl.init   = 1'b1;
            S_LOAD:  crc_ctl.absorb = cur_absorb;
            default: ;
        endcase
    end

    assign tx.valid     = (state_reg == S_SEND);
    assign tx.tx_byte   = out_byte_reg;
    assign tx.last_byte = out_last_reg;

    sbcr_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .data  (cur_byte),
        .crc   (crc_val),
        .busy  (crc_busy)
    );

    // frame memory and check-byte read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= rx.value;
        if (state_reg == S_READ)
            rd_reg <= mem[(b1 < 8'(FRAME_DEPTH)) ? b1[AW-1:0] : '0];
    end

    for (genvar g = 1; g <= 12; g++)
    begin : g_shadow
        always_ff @(posedge clk)
        begin
            if (wr_en && count_reg == CW'(g))
                shadow_reg[g] <= rx.value;
        end
    end

    // reply payload and output byte
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK)
        begin
            for (int i = 0; i < REPLY_MAX; i++)
                pl_reg[i] <= pl_next[i];
        end
        if (state_reg == S_LOAD)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= (e_reg == n_reg + 4'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            node_reg       <= '0;
            pending_reg    <= '0;
            target_reg     <= '0;
            hour_reg       <= '0;
            minute_reg     <= '0;
            check_last_reg <= '0;
            have_cfg_reg   <= 1'b0;
            have_fault_reg <= 1'b0;
            have_filt_reg  <= 1'b0;
            n_reg          <= '0;
            e_reg          <= '0;
            for (int i = 0; i < 8; i++)
                filt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (rx_fire && op == OP_SET_CMD)
                pending_reg <= rx.value;
            else if (rx_fire && op == OP_SET_TEMP)
            begin
                target_reg  <= rx.value;
                pending_reg <= CMD_TEMP;
            end
            else if (state_reg == S_CHECK)
            begin
                node_reg       <= node_next;
                pending_reg    <= pending_next;
                hour_reg       <= hour_next;
                minute_reg     <= minute_next;
                check_last_reg <= check_last_next;
                have_cfg_reg   <= have_cfg_next;
                have_fault_reg <= have_fault_next;
                have_filt_reg  <= have_filt_next;
                n_reg          <= n_next;
                e_reg          <= '0;
                for (int i = 0; i < 8; i++)
                    filt_reg[i] <= filt_next[i];
            end
            else if (state_reg == S_SEND && tx.ready)
                e_reg <= e_reg + 4'd1;
        end
    end

endmodule

`default_nettype wire

[rtl/sbcr_crc_unit.sv]
// sbcr_crc_unit: bit-serial crc-8 (poly 0x07), one shift per cycle
// depends on sbcr_pkg
`default_nettype none

module sbcr_crc_unit
    import sbcr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire crc_ctl_t   ctl,
    input  wire logic [7:0] data,
    output logic [7:0]      crc,
    output logic            busy
);

    logic [7:0] crc_reg;
    logic [3:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_SEED;
            cnt_reg <= '0;
        end
        else if (ctl.init)
        begin
            crc_reg <= CRC_SEED;
            cnt_reg <= '0;
        end
        else if (ctl.absorb)
        begin
            crc_reg <= crc_reg ^ data;
            cnt_reg <= 4'd8;
        end
        else if (cnt_reg != '0)
        begin
            crc_reg <= crc_reg[7] ? ({crc_reg[6:0], 1'b0} ^ CRC_POLY)
                                  : {crc_reg[6:0], 1'b0};
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    assign crc  = crc_reg;
    assign busy = (cnt_reg != '0);

endmodule

`default_nettype wire
